// ===== hdl/wmcj_pkg.sv =====
// Shared types and constants for the windowed minimum-cost jump block.
package wmcj_pkg;

   localparam int HEIGHT_W   = 16;
   localparam int JUMP_W     = 4;
   localparam int MIN_COST_W = 32;

   localparam logic [JUMP_W-1:0] JUMP_RESET = JUMP_W'(1);

   typedef struct packed {
      logic [HEIGHT_W-1:0] height;
      logic                first_item;
   } req_type;

   typedef struct packed {
      logic [MIN_COST_W-1:0] min_cost;
      logic                  saturated;
   } rsp_type;

endpackage

// ===== hdl/windowed_min_cost_jump.sv =====
// Top level: window of jump cells, min tree, sequence counter and output skid buffer.
// An accepted word is held in the output register, or in the skid stage on a stall.
// Throughput: one word per cycle while req_stall is low; the new cost enters cell 0
// through the cell candidates and min tree in the same cycle that the word is taken.
// Reset: synchronous, active high; clears the position count and the output
// valid flags and sets max_jump to 1. Window contents are gated by the count.
module windowed_min_cost_jump
   import wmcj_pkg::*;
#(
   parameter int MAX_JUMP  = 8,
   parameter int COST_BITS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_type           rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [JUMP_W-1:0] csr_data
);

   localparam int SEEN_W = $clog2(MAX_JUMP + 1);
   localparam int KW     = COST_BITS + 2;

   logic [JUMP_W-1:0]  max_jump_ff;
   logic [SEEN_W-1:0]  seen_ff;
   logic [SEEN_W-1:0]  seen_in;
   logic               accept;
   logic               start;

   logic [MAX_JUMP-1:0]                 cell_en;
   logic [MAX_JUMP:0][HEIGHT_W-1:0]     chain_height;
   logic [MAX_JUMP:0][COST_BITS-1:0]    chain_cost;
   logic [MAX_JUMP-1:0][KW-1:0]         keys;
   logic [KW-1:0]                       min_key;
   logic [COST_BITS-1:0]                best_cost;
   logic                                best_sat;
   rsp_type                             new_rsp;

   logic    out_valid_ff;
   rsp_type out_data_ff;
   logic    skid_valid_ff;
   rsp_type skid_data_ff;

   assign csr_ready = 1'b1;
   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign start     = req_data.first_item || (seen_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         max_jump_ff <= JUMP_RESET;
      end else if (csr_valid && csr_ready) begin
         max_jump_ff <= csr_data;
      end
   end

   // A cell takes part if it lies within the jump limit and holds a
   // position of the current sequence; a limit of zero acts as one.
   genvar j;
   generate
      for (j = 0; j < MAX_JUMP; j++) begin : g_cell
         logic in_limit;
         if (j == 0) begin : g_first
            assign in_limit = 1'b1;
         end else if (j >= (1 << JUMP_W)) begin : g_far
            assign in_limit = 1'b0;
         end else begin : g_mid
            assign in_limit = JUMP_W'(j) < max_jump_ff;
         end
         assign cell_en[j] = in_limit && (SEEN_W'(j) < seen_ff);

         wmcj_cell #(
            .COST_BITS (COST_BITS)
         ) u_cell (
            .clock      (clock),
            .shift      (accept),
            .enable     (cell_en[j]),
            .cur_height (req_data.height),
            .height_in  (chain_height[j]),
            .cost_in    (chain_cost[j]),
            .height_out (chain_height[j+1]),
            .cost_out   (chain_cost[j+1]),
            .cand_key   (keys[j])
         );
      end
   endgenerate

   wmcj_min_tree #(
      .N  (MAX_JUMP),
      .KW (KW)
   ) u_min_tree (
      .keys    (keys),
      .min_key (min_key)
   );

   assign best_cost       = start ? '0 : min_key[COST_BITS:1];
   assign best_sat        = start ? 1'b0 : min_key[0];
   assign chain_height[0] = req_data.height;
   assign chain_cost[0]   = best_cost;

   assign new_rsp.min_cost  = MIN_COST_W'(best_cost);
   assign new_rsp.saturated = best_sat;

   always_comb begin
      if (start) begin
         seen_in = SEEN_W'(1);
      end else if (seen_ff < SEEN_W'(MAX_JUMP)) begin
         seen_in = seen_ff + SEEN_W'(1);
      end else begin
         seen_in = seen_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
      end else if (accept) begin
         seen_ff <= seen_in;
      end
   end

   // Output register with a skid stage behind it.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || !rsp_stall) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= accept;
         end
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || !rsp_stall) begin
         if (skid_valid_ff) begin
            out_data_ff <= skid_data_ff;
         end else if (accept) begin
            out_data_ff <= new_rsp;
         end
      end else if (accept) begin
         skid_data_ff <= new_rsp;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

`ifndef ASSERT_OFF
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid stage holds a word while the output register is empty");

   a_new_sequence: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.first_item) |=> (seen_ff == SEEN_W'(1)))
      else $error("position count not restarted by a first item");

   a_seen_bound: assert property (@(posedge clock) disable iff (reset)
      seen_ff <= SEEN_W'(MAX_JUMP))
      else $error("position count beyond the window depth");

   a_some_candidate: assert property (@(posedge clock) disable iff (reset)
      (accept && !start) |-> cell_en[0])
      else $error("no candidate cell enabled for a continuing sequence");
`endif

endmodule

// ===== hdl/wmcj_cell.sv =====
// One window position: holds a height and its cost and forms the jump candidate.
module wmcj_cell
   import wmcj_pkg::*;
#(
   parameter int COST_BITS = 32
) (
   input  logic                  clock,
   input  logic                  shift,
   input  logic                  enable,
   input  logic [HEIGHT_W-1:0]   cur_height,
   input  logic [HEIGHT_W-1:0]   height_in,
   input  logic [COST_BITS-1:0]  cost_in,
   output logic [HEIGHT_W-1:0]   height_out,
   output logic [COST_BITS-1:0]  cost_out,
   output logic [COST_BITS+1:0]  cand_key
);

   logic [HEIGHT_W-1:0]  height_ff;
   logic [COST_BITS-1:0] cost_ff;
   logic [HEIGHT_W-1:0]  diff;
   logic [COST_BITS:0]   sum;
   logic                 clip;
   logic [COST_BITS-1:0] cand_cost;

   always_ff @(posedge clock) begin
      if (shift) begin
         height_ff <= height_in;
         cost_ff   <= cost_in;
      end
   end

   assign diff      = (cur_height >= height_ff) ? (cur_height - height_ff)
                                                : (height_ff - cur_height);
   assign sum       = {1'b0, cost_ff} + (COST_BITS+1)'(diff);
   assign clip      = sum[COST_BITS];
   assign cand_cost = clip ? {COST_BITS{1'b1}} : sum[COST_BITS-1:0];

   // Key orders disabled cells last and, on equal cost, unclipped first.
   // A disabled cell shows all ones so that its held contents never reach the tree.
   assign cand_key   = enable ? {1'b0, cand_cost, clip} : {(COST_BITS+2){1'b1}};
   assign height_out = height_ff;
   assign cost_out   = cost_ff;

endmodule

// ===== hdl/wmcj_min_tree.sv =====
// Balanced comparison tree that picks the smallest of the cell keys.
module wmcj_min_tree #(
   parameter int N  = 8,
   parameter int KW = 34
) (
   input  logic [N-1:0][KW-1:0] keys,
   output logic [KW-1:0]        min_key
);

   localparam int P = 2 ** $clog2(N);

   logic [2*P-2:0][KW-1:0] node;

   genvar i;
   generate
      for (i = 0; i < P; i++) begin : g_leaf
         if (i < N) begin : g_used
            assign node[P-1+i] = keys[i];
         end else begin : g_pad
            assign node[P-1+i] = {KW{1'b1}};
         end
      end
      for (i = 0; i < P-1; i++) begin : g_node
         assign node[i] = (node[2*i+2] < node[2*i+1]) ? node[2*i+2] : node[2*i+1];
      end
   endgenerate

   assign min_key = node[0];

endmodule
